FILE: hdl/tccw_pkg.sv
// Package for the text console character writer: screen geometry, codes and types.
// Used by tccw_rem and text_console_char_writer_unit.
package tccw_pkg;

  localparam int COLUMNS   = 80;
  localparam int LINES     = 25;
  localparam int TAB_WIDTH = 8;
  localparam int CELLS     = COLUMNS * LINES;

  localparam int ADDR_W = $clog2(CELLS);
  localparam int WORK_W = $clog2(CELLS + COLUMNS + TAB_WIDTH);

  localparam int IN_TDATA_W  = 24;
  localparam int OUT_TDATA_W = 32;

  localparam logic [15:0] BLANK_CELL = 16'h0720;

  localparam logic [7:0] CH_NL  = 8'h0A;
  localparam logic [7:0] CH_TAB = 8'h09;
  localparam logic [7:0] CH_BS  = 8'h08;

  localparam logic FUNC_PUT  = 1'b0;
  localparam logic FUNC_READ = 1'b1;

  typedef struct packed {
    logic              start;
    logic              use_tab;
    logic [WORK_W-1:0] value;
  } rem_req_t;

  typedef struct packed {
    logic              done;
    logic [WORK_W-1:0] value;
  } rem_rsp_t;

endpackage

FILE: hdl/tccw_rem.sv
// Iterative remainder unit: repeated subtraction of COLUMNS or TAB_WIDTH.
// Depends on tccw_pkg.
module tccw_rem (
  input  logic               clk,
  input  logic               rst,
  input  tccw_pkg::rem_req_t req,
  output tccw_pkg::rem_rsp_t rsp
);

  logic                        busy;
  logic [tccw_pkg::WORK_W-1:0] r;
  logic [tccw_pkg::WORK_W-1:0] d;

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
    end else if (req.start) begin
      busy <= 1'b1;
      r    <= req.value;
      d    <= req.use_tab ? tccw_pkg::WORK_W'(tccw_pkg::TAB_WIDTH)
                          : tccw_pkg::WORK_W'(tccw_pkg::COLUMNS);
    end else if (busy) begin
      if (r >= d) begin
        r <= r - d;
      end else begin
        busy <= 1'b0;
      end
    end
  end

  assign rsp.done  = busy && (r < d);
  assign rsp.value = r;

endmodule

FILE: hdl/text_console_char_writer_unit.sv
// Text console character writer: cursor, screen store and put/read sequencer.
// Depends on tccw_pkg and tccw_rem. One item at a time: input is taken only in the
// idle state. Newline, tab and backspace wait on the remainder unit (one subtract
// a cycle); a scroll moves the store up by one line (one store cell moved a cycle).
// Output stalls hold the result in the finish state.
// Reset: cursor 0; a clearing pass blanks the store before input.
module text_console_char_writer_unit (
  input  logic        clk,
  input  logic        rst,
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  input  logic [23:0] s_axis_tdata,   // char_code[7:0], cell_index[18:8], zero pad
  input  logic        s_axis_tuser,   // func
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  output logic [31:0] m_axis_tdata    // cursor_pos[10:0], cell_value[26:11], scrolled[27]
);

  localparam int AW = tccw_pkg::ADDR_W;
  localparam int WW = tccw_pkg::WORK_W;
  localparam logic [AW-1:0] LAST_CELL = AW'(tccw_pkg::CELLS - 1);
  localparam logic [AW-1:0] MOVE_END  = AW'(tccw_pkg::CELLS - tccw_pkg::COLUMNS);

  typedef enum logic [3:0] {
    ST_CLEAR, ST_IDLE, ST_RD_WAIT, ST_PUT_WR, ST_REM, ST_CHK,
    ST_SCROLL, ST_SC_END, ST_FINISH
  } state_t;

  state_t state;

  logic [AW-1:0] cursor;
  logic [AW-1:0] scnt;
  logic [WW-1:0] wcur;
  logic [WW-1:0] wsub;
  logic [7:0]    ch;
  logic [15:0]   res_cell;
  logic          res_scr;
  logic          rd_ok;
  logic          mv_pend;
  logic          mv_blank;
  logic [AW-1:0] mv_addr;

  logic [15:0]   mem [tccw_pkg::CELLS];
  logic [15:0]   rdata;
  logic [AW-1:0] raddr;
  logic          we;
  logic [AW-1:0] waddr;
  logic [15:0]   wdata;

  logic          accept;
  logic          in_func;
  logic [7:0]    in_ch;
  logic [10:0]   in_idx;
  logic          in_special;

  tccw_pkg::rem_req_t rem_req;
  tccw_pkg::rem_rsp_t rem_rsp;

  assign s_axis_tready = (state == ST_IDLE);
  assign accept        = s_axis_tvalid && s_axis_tready;
  assign in_func       = s_axis_tuser;
  assign in_ch         = s_axis_tdata[7:0];
  assign in_idx        = s_axis_tdata[18:8];
  assign in_special    = (in_ch == tccw_pkg::CH_NL) || (in_ch == tccw_pkg::CH_TAB) ||
                         (in_ch == tccw_pkg::CH_BS);

  assign rem_req.start   = accept && (in_func == tccw_pkg::FUNC_PUT) && in_special;
  assign rem_req.use_tab = (in_ch == tccw_pkg::CH_TAB);
  assign rem_req.value   = WW'(cursor);

  tccw_rem u_rem (
    .clk (clk),
    .rst (rst),
    .req (rem_req),
    .rsp (rem_rsp)
  );

  assign wsub = wcur - WW'(tccw_pkg::COLUMNS);

  always_comb begin
    if (state == ST_IDLE) begin
      raddr = (in_func == tccw_pkg::FUNC_READ) ? AW'(in_idx) : cursor;
    end else begin
      raddr = scnt + AW'(tccw_pkg::COLUMNS);
    end
  end

  always_comb begin
    we    = 1'b0;
    waddr = mv_addr;
    wdata = mv_blank ? tccw_pkg::BLANK_CELL : rdata;
    case (state)
      ST_CLEAR: begin
        we    = 1'b1;
        waddr = scnt;
        wdata = tccw_pkg::BLANK_CELL;
      end
      ST_PUT_WR: begin
        we    = 1'b1;
        waddr = cursor;
        wdata = {rdata[15:8], ch};
      end
      ST_SCROLL, ST_SC_END: begin
        we = mv_pend;
      end
      default: begin
        we = 1'b0;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state         <= ST_CLEAR;
      cursor        <= '0;
      scnt          <= '0;
      mv_pend       <= 1'b0;
      m_axis_tvalid <= 1'b0;
    end else begin
      if (state == ST_FINISH && (!m_axis_tvalid || m_axis_tready)) begin
        m_axis_tvalid <= 1'b1;
      end else if (m_axis_tvalid && m_axis_tready) begin
        m_axis_tvalid <= 1'b0;
      end
      case (state)
        ST_CLEAR: begin
          if (scnt == LAST_CELL) begin
            scnt  <= '0;
            state <= ST_IDLE;
          end else begin
            scnt <= scnt + AW'(1);
          end
        end
        ST_IDLE: begin
          if (accept) begin
            res_cell <= '0;
            res_scr  <= 1'b0;
            if (in_func == tccw_pkg::FUNC_READ) begin
              rd_ok <= (32'(in_idx) < 32'(tccw_pkg::CELLS));
              state <= ST_RD_WAIT;
            end else begin
              ch    <= in_ch;
              state <= in_special ? ST_REM : ST_PUT_WR;
            end
          end
        end
        ST_RD_WAIT: begin
          res_cell <= rd_ok ? rdata : 16'h0000;
          state    <= ST_FINISH;
        end
        ST_PUT_WR: begin
          wcur  <= WW'(cursor) + WW'(1);
          state <= ST_CHK;
        end
        ST_REM: begin
          if (rem_rsp.done) begin
            case (ch)
              tccw_pkg::CH_NL: begin
                wcur <= WW'(cursor) + WW'(tccw_pkg::COLUMNS) - rem_rsp.value;
              end
              tccw_pkg::CH_TAB: begin
                wcur <= WW'(cursor) + WW'(tccw_pkg::TAB_WIDTH) - rem_rsp.value;
              end
              default: begin
                wcur <= (rem_rsp.value != '0) ? WW'(cursor) - WW'(1) : WW'(cursor);
              end
            endcase
            state <= ST_CHK;
          end
        end
        ST_CHK: begin
          if (wcur >= WW'(tccw_pkg::CELLS)) begin
            res_scr <= 1'b1;
            scnt    <= '0;
            mv_pend <= 1'b0;
            cursor  <= (wsub >= WW'(tccw_pkg::CELLS)) ? LAST_CELL : AW'(wsub);
            state   <= ST_SCROLL;
          end else begin
            cursor <= AW'(wcur);
            state  <= ST_FINISH;
          end
        end
        ST_SCROLL: begin
          mv_pend  <= 1'b1;
          mv_addr  <= scnt;
          mv_blank <= (scnt >= MOVE_END);
          scnt     <= scnt + AW'(1);
          if (scnt == LAST_CELL) begin
            state <= ST_SC_END;
          end
        end
        ST_SC_END: begin
          mv_pend <= 1'b0;
          state   <= ST_FINISH;
        end
        ST_FINISH: begin
          if (!m_axis_tvalid || m_axis_tready) begin
            m_axis_tdata <= {4'b0000, res_scr, res_cell, 11'(cursor)};
            state        <= ST_IDLE;
          end
        end
        default: begin
          state <= ST_IDLE;
        end
      endcase
    end
  end

endmodule

FILE: dv/tccw_console_checker.sv
`timescale 1ns / 100ps
// Checker for text_console_char_writer_unit: watches both stream channels and keeps
// its own copy of the cursor and screen store to predict every result.
// Depends on tccw_pkg.
module tccw_console_checker
  import tccw_pkg::*;
(
  input  logic        clk,
  input  logic        rst,
  input  logic        s_axis_tvalid,
  input  logic        s_axis_tready,
  input  logic [23:0] s_axis_tdata,   // char_code[7:0], cell_index[18:8], zero pad
  input  logic        s_axis_tuser,   // func
  input  logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  input  logic [31:0] m_axis_tdata,   // cursor_pos[10:0], cell_value[26:11], scrolled[27]
  output int          errors,
  output int          outstanding,
  output int          results_checked,
  output int          scroll_count,
  output int          read_count
);

  typedef struct packed {
    logic [10:0] cursor_pos;
    logic [15:0] cell_value;
    logic        scrolled;
  } console_result_t;

  logic [15:0]     screen_mem [CELLS];
  int unsigned     cursor_at;
  console_result_t result_q [$];
  console_result_t got, want;
  int              n_err = 0;
  int              n_checked = 0;
  int              n_scroll = 0;
  int              n_read = 0;

  function automatic console_result_t console_apply(logic func, logic [7:0] ch,
                                                    logic [10:0] idx);
    console_result_t r;
    int i;
    r = '0;
    if (cursor_at >= CELLS) cursor_at = CELLS - 1;
    if (func == FUNC_READ) begin
      if (idx < CELLS) r.cell_value = screen_mem[idx];
    end else begin
      if (ch == CH_NL) begin
        cursor_at = cursor_at + COLUMNS - cursor_at % COLUMNS;
      end else if (ch == CH_TAB) begin
        cursor_at = cursor_at + TAB_WIDTH - cursor_at % TAB_WIDTH;
      end else if (ch == CH_BS) begin
        if (cursor_at % COLUMNS != 0) cursor_at = cursor_at - 1;
      end else begin
        screen_mem[cursor_at][7:0] = ch;
        cursor_at = cursor_at + 1;
      end
      // one scroll per put at most, then saturate
      if (cursor_at >= CELLS) begin
        for (i = 0; i < CELLS - COLUMNS; i++) screen_mem[i] = screen_mem[i + COLUMNS];
        for (i = CELLS - COLUMNS; i < CELLS; i++) screen_mem[i] = BLANK_CELL;
        cursor_at = cursor_at - COLUMNS;
        if (cursor_at >= CELLS) cursor_at = CELLS - 1;
        r.scrolled = 1'b1;
      end
    end
    r.cursor_pos = cursor_at[10:0];
    return r;
  endfunction

  always @(posedge clk) begin
    if (rst) begin
      cursor_at = 0;
      for (int i = 0; i < CELLS; i++) screen_mem[i] = BLANK_CELL;
      result_q.delete();
    end else begin
      if (m_axis_tvalid && m_axis_tready) begin
        got = {m_axis_tdata[10:0], m_axis_tdata[26:11], m_axis_tdata[27]};
        if (result_q.size() == 0) begin
          n_err++;
          $error("result transfer with nothing pending: tdata %h", m_axis_tdata);
        end else begin
          want = result_q.pop_front();
          n_checked++;
          if (got.cursor_pos !== want.cursor_pos) begin
            n_err++;
            $error("cursor_pos: expected %0d, got %0d", want.cursor_pos, got.cursor_pos);
          end
          if (got.cell_value !== want.cell_value) begin
            n_err++;
            $error("cell_value: expected %h, got %h", want.cell_value, got.cell_value);
          end
          if (got.scrolled !== want.scrolled) begin
            n_err++;
            $error("scrolled: expected %0d, got %0d", want.scrolled, got.scrolled);
          end
        end
      end
      if (s_axis_tvalid && s_axis_tready) begin
        want = console_apply(s_axis_tuser, s_axis_tdata[7:0], s_axis_tdata[18:8]);
        result_q.push_back(want);
        if (want.scrolled) n_scroll++;
        if (s_axis_tuser == FUNC_READ) n_read++;
      end
    end
    errors          <= n_err;
    outstanding     <= result_q.size();
    results_checked <= n_checked;
    scroll_count    <= n_scroll;
    read_count      <= n_read;
  end

endmodule

FILE: dv/tb_text_console_char_writer_unit.sv
`timescale 1ns / 100ps
// Testbench top for text_console_char_writer_unit: directed and random put/read
// traffic with bursty input and stalling output. Depends on tccw_pkg and tccw_console_checker.
module tb_text_console_char_writer_unit;
  import tccw_pkg::*;

  localparam int DIRECTED_ITEMS = 22;
  localparam int RANDOM_ITEMS   = 300;
  localparam int CYCLE_LIMIT    = 4_000_000;

  logic        clk = 1'b0;
  logic        rst;
  logic        s_axis_tvalid;
  logic        s_axis_tready;
  logic [23:0] s_axis_tdata;
  logic        s_axis_tuser;
  logic        m_axis_tvalid;
  logic        m_axis_tready;
  logic [31:0] m_axis_tdata;

  int errors, outstanding, results_checked, scroll_count, read_count;
  int items_sent = 0;
  int burst_left = 0;
  int cycles = 0;
  int holdoffs = 0;

  always #2 clk = ~clk;

  text_console_char_writer_unit dut (
    .clk           (clk),
    .rst           (rst),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tuser  (s_axis_tuser),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata)
  );

  tccw_console_checker checker_i (
    .clk             (clk),
    .rst             (rst),
    .s_axis_tvalid   (s_axis_tvalid),
    .s_axis_tready   (s_axis_tready),
    .s_axis_tdata    (s_axis_tdata),
    .s_axis_tuser    (s_axis_tuser),
    .m_axis_tvalid   (m_axis_tvalid),
    .m_axis_tready   (m_axis_tready),
    .m_axis_tdata    (m_axis_tdata),
    .errors          (errors),
    .outstanding     (outstanding),
    .results_checked (results_checked),
    .scroll_count    (scroll_count),
    .read_count      (read_count)
  );

  // bursts of random length, random gaps in between
  task automatic send_item(input logic func, input logic [7:0] ch, input logic [10:0] idx);
    s_axis_tvalid <= 1'b1;
    s_axis_tdata  <= {5'b0, idx, ch};
    s_axis_tuser  <= func;
    @(posedge clk);
    while (!s_axis_tready) @(posedge clk);
    items_sent++;
    if (burst_left > 0) begin
      burst_left--;
    end else begin
      s_axis_tvalid <= 1'b0;
      repeat ($urandom_range(1, 15)) @(posedge clk);
      burst_left = ($urandom_range(0, 3) == 0) ? $urandom_range(20, 60) : $urandom_range(0, 8);
    end
  endtask

  task automatic put_char(input logic [7:0] ch);
    send_item(FUNC_PUT, ch, 11'($urandom_range(0, 2047)));
  endtask

  task automatic read_cell(input logic [10:0] idx);
    send_item(FUNC_READ, 8'($urandom_range(0, 255)), idx);
  endtask

  function automatic logic [7:0] text_byte();
    logic [7:0] b;
    do b = 8'($urandom_range(0, 255)); while (b == CH_NL || b == CH_TAB || b == CH_BS);
    return b;
  endfunction

  function automatic logic [10:0] pick_cell();
    case ($urandom_range(0, 3))
      0:       return 11'($urandom_range(0, 2047));
      1:       return 11'($urandom_range(0, 2 * COLUMNS - 1));
      2:       return 11'($urandom_range(CELLS - COLUMNS, CELLS - 1));
      default: return 11'($urandom_range(CELLS - 4, 2047));
    endcase
  endfunction

  // receiver: random stall modes, plus two long hold-offs while input keeps coming
  initial begin
    int mode;
    int run_left;
    mode = 0;
    run_left = 0;
    m_axis_tready = 1'b0;
    forever begin
      @(posedge clk);
      if ((holdoffs == 0 && items_sent >= 40) || (holdoffs == 1 && items_sent >= 220)) begin
        holdoffs++;
        m_axis_tready <= 1'b0;
        repeat (500) @(posedge clk);
      end
      if (run_left == 0) begin
        mode = $urandom_range(0, 3);
        run_left = $urandom_range(5, 60);
      end
      run_left--;
      case (mode)
        0:       m_axis_tready <= 1'b1;
        1:       m_axis_tready <= 1'($urandom_range(0, 1));
        2:       m_axis_tready <= ($urandom_range(0, 3) == 0);
        default: m_axis_tready <= 1'b0;
      endcase
    end
  end

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles > CYCLE_LIMIT) begin
      $display("RESULT: ERROR");
      $finish;
    end
  end

  initial begin
    int kind;
    int n;
    rst = 1'b1;
    s_axis_tvalid = 1'b0;
    s_axis_tdata = '0;
    s_axis_tuser = FUNC_PUT;
    repeat (6) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // directed: blank reads, range edges, byte extremes, tab/backspace/newline
    read_cell(11'd0);
    read_cell(11'(CELLS - 1));
    read_cell(11'(CELLS));
    read_cell(11'h7FF);
    put_char(CH_BS);
    put_char(8'h00);
    put_char(8'hFF);
    put_char(8'h41);
    read_cell(11'd0);
    read_cell(11'd1);
    read_cell(11'd2);
    put_char(CH_BS);
    put_char(8'h7F);
    put_char(CH_TAB);
    put_char(CH_TAB);
    put_char(CH_NL);
    put_char(CH_BS);
    put_char(8'h0B);
    send_item(FUNC_PUT, CH_NL, 11'h7FF);
    send_item(FUNC_READ, 8'hFF, 11'd1);
    read_cell(11'(COLUMNS + 1));
    send_item(FUNC_READ, CH_NL, 11'(COLUMNS));

    // random: text lines, tab runs, backspaces, read bursts, some noise
    while (items_sent < DIRECTED_ITEMS + RANDOM_ITEMS) begin
      kind = $urandom_range(0, 99);
      if (kind < 45) begin
        n = $urandom_range(0, 14);
        repeat (n) put_char(text_byte());
        if ($urandom_range(0, 3) != 0) put_char(CH_NL);
      end else if (kind < 57) begin
        n = $urandom_range(1, 12);
        repeat (n) put_char(CH_TAB);
      end else if (kind < 65) begin
        n = $urandom_range(0, 4);
        repeat (n) put_char(text_byte());
        n = $urandom_range(1, 6);
        repeat (n) put_char(CH_BS);
      end else if (kind < 90) begin
        n = $urandom_range(1, 4);
        repeat (n) read_cell(pick_cell());
      end else begin
        send_item(1'($urandom_range(0, 1)), 8'($urandom_range(0, 255)),
                  11'($urandom_range(0, 2047)));
      end
    end
    s_axis_tvalid <= 1'b0;

    @(posedge clk);
    while (outstanding != 0) @(posedge clk);
    repeat (CELLS + 300) @(posedge clk);

    $display("Sent %0d items (%0d reads), checked %0d results, saw %0d scrolls.",
             items_sent, read_count, results_checked, scroll_count);
    $display("Output held off for long stretches %0d times.", holdoffs);
    if (errors == 0 && outstanding == 0) begin
      $display("RESULT: OK");
    end else begin
      $display("RESULT: ERROR");
    end
    $finish;
  end

endmodule

FILE: files.f
hdl/tccw_pkg.sv
hdl/tccw_rem.sv
hdl/text_console_char_writer_unit.sv
dv/tccw_console_checker.sv
dv/tb_text_console_char_writer_unit.sv
